// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BBA_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication
`define BBA_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`else

`define BBA_ASSERT_IMP(label, clk, rst, a, b)
`define BBA_ASSERT_NXT(label, clk, rst, a, b)

`endif

`endif

// ===== rtl/core/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

   // default geometry and register reset
   localparam int POOL_ORDER_DEF = 16;
   localparam int MIN_ORDER_DEF  = 5;
   localparam logic [6:0] HDR_RESET = 7'd24;

   // node codes
   localparam logic [1:0] ST_ABSENT = 2'd0;
   localparam logic [1:0] ST_FREE   = 2'd1;
   localparam logic [1:0] ST_SPLIT  = 2'd2;
   localparam logic [1:0] ST_ALLOC  = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_TOO_BIG  = 2'd2;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd3;

   // request command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // datapath operation codes
   localparam logic [4:0] OP_NOP      = 5'd0;
   localparam logic [4:0] OP_CLR      = 5'd1;
   localparam logic [4:0] OP_CAPTURE  = 5'd2;
   localparam logic [4:0] OP_TOOBIG   = 5'd3;
   localparam logic [4:0] OP_A_INIT   = 5'd4;
   localparam logic [4:0] OP_RD_NODE  = 5'd5;
   localparam logic [4:0] OP_A_NEXT   = 5'd6;
   localparam logic [4:0] OP_A_UP     = 5'd7;
   localparam logic [4:0] OP_NOFREE   = 5'd8;
   localparam logic [4:0] OP_SPLIT1   = 5'd9;
   localparam logic [4:0] OP_SPLIT2   = 5'd10;
   localparam logic [4:0] OP_MARK     = 5'd11;
   localparam logic [4:0] OP_F_INIT   = 5'd12;
   localparam logic [4:0] OP_F_BAD    = 5'd13;
   localparam logic [4:0] OP_F_DESC   = 5'd14;
   localparam logic [4:0] OP_F_MARK   = 5'd15;
   localparam logic [4:0] OP_RD_BUDDY = 5'd16;
   localparam logic [4:0] OP_M_W1     = 5'd17;
   localparam logic [4:0] OP_M_W2     = 5'd18;
   localparam logic [4:0] OP_M_W3     = 5'd19;
   localparam logic [4:0] OP_F_DONE   = 5'd20;
   localparam logic [4:0] OP_LOAD_RSP = 5'd21;

   typedef struct packed {
      logic [4:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic is_split;
      logic is_alloc;
      logic is_alloc_cmd;
      logic too_big;
      logic out_range;
      logic last_in_level;
      logic lvl_is_pool;
      logic lvl_gt_k;
      logic lvl_gt_k1;
      logic ord_gt_min;
      logic aligned;
      logic is_root;
      logic clr_last;
      logic rsp_busy;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== rtl/core/bba_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] request_size;
   logic [15:0] block_offset;

   modport source (output valid, cmd, request_size, block_offset, input ready);
   modport sink   (input valid, cmd, request_size, block_offset, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bba_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [15:0] alloc_offset;
   logic [4:0]  alloc_order;
   logic [1:0]  status;
   logic [11:0] live_count;

   modport source (output valid, ok, alloc_offset, alloc_order, status, live_count,
                   input ready);
   modport sink   (input valid, ok, alloc_offset, alloc_order, status, live_count,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bba_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bba_datapath #(
   parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
   parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire bba_pkg::dp_cmd_type cmd,
   output bba_pkg::dp_stat_type     stat,
   input  wire                      req_cmd,
   input  wire [15:0]               req_request_size,
   input  wire [15:0]               req_block_offset,
   input  wire                      csr_wr_en,
   input  wire [6:0]                csr_wr_data,
   input  wire                      rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_ok,
   output logic [15:0]              rsp_alloc_offset,
   output logic [4:0]               rsp_alloc_order,
   output logic [1:0]               rsp_status,
   output logic [11:0]              rsp_live_count
);
   import bba_pkg::*;

   localparam int TLW   = POOL_ORDER - MIN_ORDER + 1;
   localparam int DEPTH = 1 << TLW;
   localparam int EW    = (POOL_ORDER + 1 > 17) ? POOL_ORDER + 1 : 17;

   // node tree memory
   logic [1:0] mem [DEPTH];
   logic [1:0] rd_ff;

   logic [TLW-1:0] clr_ff, clr_in;
   logic [11:0]    live_ff, live_in;
   logic [6:0]     hdr_ff, hdr_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           cmd_ff;
   logic [15:0]    size_ff, boff_ff;
   logic [TLW-1:0] node_ff;
   logic [4:0]     lvl_ff, ord_ff;
   logic           res_ok_ff;
   logic [15:0]    res_off_ff;
   logic [4:0]     res_ord_ff;
   logic [1:0]     res_st_ff;
   logic           rsp_ok_ff;
   logic [15:0]    rsp_off_ff;
   logic [4:0]     rsp_ord_ff;
   logic [1:0]     rsp_st_ff;
   logic [11:0]    rsp_live_ff;

   logic           we;
   logic [TLW-1:0] wa, ra;
   logic [1:0]     wd;

   logic [16:0]    need;
   logic [4:0]     k_val;
   logic [EW-1:0]  off_ext, off_sh, off_full;
   logic [4:0]     ord_m1;
   logic [TLW-1:0] base_k, base_up, idx;

   // block sizing from captured request
   assign need = {1'b0, size_ff} + 17'(hdr_ff);
   always_comb begin
      k_val = 5'(MIN_ORDER);
      for (int i = MIN_ORDER; i < 17; i++) begin
         if (need > (17'(1) << i)) k_val = 5'(i + 1);
      end
   end

   assign off_ext  = EW'(boff_ff);
   assign ord_m1   = ord_ff - 5'd1;
   assign off_sh   = off_ext >> ord_m1;
   assign base_k   = TLW'(1) << (5'(POOL_ORDER) - k_val);
   assign base_up  = TLW'(1) << (5'(POOL_ORDER) - lvl_ff - 5'd1);
   assign idx      = node_ff - base_k;
   assign off_full = EW'(idx) << k_val;

   // status to controller
   always_comb begin
      stat.is_free       = rd_ff == ST_FREE;
      stat.is_split      = rd_ff == ST_SPLIT;
      stat.is_alloc      = rd_ff == ST_ALLOC;
      stat.is_alloc_cmd  = cmd_ff == CMD_ALLOC;
      stat.too_big       = k_val > 5'(POOL_ORDER);
      stat.out_range     = off_ext >= (EW'(1) << POOL_ORDER);
      stat.last_in_level = (node_ff & (node_ff + TLW'(1))) == '0;
      stat.lvl_is_pool   = lvl_ff == 5'(POOL_ORDER);
      stat.lvl_gt_k      = lvl_ff > k_val;
      stat.lvl_gt_k1     = lvl_ff > (k_val + 5'd1);
      stat.ord_gt_min    = ord_ff > 5'(MIN_ORDER);
      stat.aligned       = (off_ext & ((EW'(1) << ord_ff) - EW'(1))) == '0;
      stat.is_root       = node_ff == TLW'(1);
      stat.clr_last      = &clr_ff;
      stat.rsp_busy      = rsp_valid_ff && !rsp_ready;
   end

   // memory write and read address
   always_comb begin
      we = 1'b0;
      wa = node_ff;
      wd = ST_ABSENT;
      ra = (cmd.op == OP_RD_BUDDY) ? (node_ff ^ TLW'(1)) : node_ff;
      case (cmd.op)
         OP_CLR: begin
            we = 1'b1;
            wa = clr_ff;
            wd = (clr_ff == TLW'(1)) ? ST_FREE : ST_ABSENT;
         end
         OP_SPLIT1: begin
            we = 1'b1;
            wd = ST_SPLIT;
         end
         OP_SPLIT2: begin
            we = 1'b1;
            wa = {node_ff[TLW-2:0], 1'b1};
            wd = ST_FREE;
         end
         OP_MARK: begin
            we = 1'b1;
            wd = ST_ALLOC;
         end
         OP_F_MARK, OP_M_W3: begin
            we = 1'b1;
            wd = ST_FREE;
         end
         OP_M_W1: begin
            we = 1'b1;
         end
         OP_M_W2: begin
            we = 1'b1;
            wa = node_ff ^ TLW'(1);
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   // control registers next values
   always_comb begin
      clr_in       = clr_ff;
      live_in      = live_ff;
      hdr_in       = csr_wr_en ? csr_wr_data : hdr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         OP_CLR:      clr_in = clr_ff + TLW'(1);
         OP_MARK:     live_in = live_ff + 12'd1;
         OP_F_DONE:   live_in = live_ff - 12'd1;
         OP_LOAD_RSP: rsp_valid_in = 1'b1;
         default:     clr_in = clr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         live_ff      <= '0;
         hdr_ff       <= HDR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         hdr_ff       <= hdr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk registers and results
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            cmd_ff  <= req_cmd;
            size_ff <= req_request_size;
            boff_ff <= req_block_offset;
         end
         OP_A_INIT: begin
            node_ff <= base_k;
            lvl_ff  <= k_val;
         end
         OP_A_NEXT: node_ff <= node_ff + TLW'(1);
         OP_A_UP: begin
            node_ff <= base_up;
            lvl_ff  <= lvl_ff + 5'd1;
         end
         OP_SPLIT2: begin
            node_ff <= {node_ff[TLW-2:0], 1'b0};
            lvl_ff  <= lvl_ff - 5'd1;
         end
         OP_MARK: begin
            res_ok_ff  <= 1'b1;
            res_off_ff <= off_full[15:0];
            res_ord_ff <= k_val;
            res_st_ff  <= STATUS_OK;
         end
         OP_TOOBIG: begin
            res_ok_ff  <= 1'b0;
            res_off_ff <= '0;
            res_ord_ff <= k_val;
            res_st_ff  <= STATUS_TOO_BIG;
         end
         OP_NOFREE: begin
            res_ok_ff  <= 1'b0;
            res_off_ff <= '0;
            res_ord_ff <= k_val;
            res_st_ff  <= STATUS_NO_SPACE;
         end
         OP_F_BAD: begin
            res_ok_ff  <= 1'b0;
            res_off_ff <= '0;
            res_ord_ff <= '0;
            res_st_ff  <= STATUS_BAD_FREE;
         end
         OP_F_INIT: begin
            node_ff <= TLW'(1);
            ord_ff  <= 5'(POOL_ORDER);
         end
         OP_F_DESC: begin
            node_ff <= {node_ff[TLW-2:0], off_sh[0]};
            ord_ff  <= ord_m1;
         end
         OP_M_W2: node_ff <= node_ff >> 1;
         OP_F_DONE: begin
            res_ok_ff  <= 1'b1;
            res_off_ff <= '0;
            res_ord_ff <= ord_ff;
            res_st_ff  <= STATUS_OK;
         end
         OP_LOAD_RSP: begin
            rsp_ok_ff   <= res_ok_ff;
            rsp_off_ff  <= res_off_ff;
            rsp_ord_ff  <= res_ord_ff;
            rsp_st_ff   <= res_st_ff;
            rsp_live_ff <= live_ff;
         end
         default: begin
            rsp_ok_ff <= rsp_ok_ff;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_alloc_offset = rsp_off_ff;
   assign rsp_alloc_order  = rsp_ord_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_live_count   = rsp_live_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bba_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bba_controller (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire bba_pkg::dp_stat_type stat,
   output bba_pkg::dp_cmd_type       cmd
);
   import bba_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DISP  = 4'd2;
   localparam logic [3:0] S_A_RD  = 4'd3;
   localparam logic [3:0] S_A_CHK = 4'd4;
   localparam logic [3:0] S_SPL1  = 4'd5;
   localparam logic [3:0] S_SPL2  = 4'd6;
   localparam logic [3:0] S_MARK  = 4'd7;
   localparam logic [3:0] S_F_RD  = 4'd8;
   localparam logic [3:0] S_F_CHK = 4'd9;
   localparam logic [3:0] S_M_RD  = 4'd10;
   localparam logic [3:0] S_M_CHK = 4'd11;
   localparam logic [3:0] S_M_W2  = 4'd12;
   localparam logic [3:0] S_M_W3  = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   logic [3:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   // sequencing of search, split, descend and merge
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLR;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.is_alloc_cmd) begin
               if (stat.too_big) begin
                  cmd.op   = OP_TOOBIG;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_A_INIT;
                  state_in = S_A_RD;
               end
            end else if (stat.out_range) begin
               cmd.op   = OP_F_BAD;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_F_INIT;
               state_in = S_F_RD;
            end
         end
         S_A_RD: begin
            cmd.op   = OP_RD_NODE;
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            if (stat.is_free) begin
               state_in = stat.lvl_gt_k ? S_SPL1 : S_MARK;
            end else if (stat.last_in_level) begin
               if (stat.lvl_is_pool) begin
                  cmd.op   = OP_NOFREE;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_A_UP;
                  state_in = S_A_RD;
               end
            end else begin
               cmd.op   = OP_A_NEXT;
               state_in = S_A_RD;
            end
         end
         S_SPL1: begin
            cmd.op   = OP_SPLIT1;
            state_in = S_SPL2;
         end
         S_SPL2: begin
            cmd.op   = OP_SPLIT2;
            state_in = stat.lvl_gt_k1 ? S_SPL1 : S_MARK;
         end
         S_MARK: begin
            cmd.op   = OP_MARK;
            state_in = S_DONE;
         end
         S_F_RD: begin
            cmd.op   = OP_RD_NODE;
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (stat.is_split && stat.ord_gt_min) begin
               cmd.op   = OP_F_DESC;
               state_in = S_F_RD;
            end else if (!stat.is_alloc || !stat.aligned) begin
               cmd.op   = OP_F_BAD;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_F_MARK;
               state_in = S_M_RD;
            end
         end
         S_M_RD: begin
            if (stat.is_root) begin
               cmd.op   = OP_F_DONE;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_RD_BUDDY;
               state_in = S_M_CHK;
            end
         end
         S_M_CHK: begin
            if (stat.is_free) begin
               cmd.op   = OP_M_W1;
               state_in = S_M_W2;
            end else begin
               cmd.op   = OP_F_DONE;
               state_in = S_DONE;
            end
         end
         S_M_W2: begin
            cmd.op   = OP_M_W2;
            state_in = S_M_W3;
         end
         S_M_W3: begin
            cmd.op   = OP_M_W3;
            state_in = S_M_RD;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_LOAD_RSP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/buddy_block_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake     payload
// req_chan  in   valid/ready   cmd, request_size, block_offset
// rsp_chan  out  valid/ready   ok, alloc_offset, alloc_order, status, live_count
// csr       in   csr_wr_en     csr_wr_data (header bytes)
//
// one request at a time; the node tree memory reads set the pace
// allocate: a read and check per node scanned (up to 2^(POOL-MIN+1)), then splits
// free: a read and check per level descended; a read and three writes per buddy merge
// after reset a clearing pass over all 2^(POOL_ORDER-MIN_ORDER+1) tree memory
// entries (4096 by default) holds req_chan.ready low; csr writes are taken throughout
// a waiting response holds the next result in S_DONE; the next request is still taken
`include "assert_macros.svh"
module buddy_block_allocator_core #(
   parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
   parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
   input  wire        clock,
   input  wire        reset,
   bba_req_if.sink    req_chan,
   bba_rsp_if.source  rsp_chan,
   input  wire        csr_wr_en,
   input  wire [6:0]  csr_wr_data
);
   import bba_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        ready;

   // sequencer
   bba_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tree memory, walk registers, response register
   bba_datapath #(
      .POOL_ORDER (POOL_ORDER),
      .MIN_ORDER  (MIN_ORDER)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_chan.cmd),
      .req_request_size (req_chan.request_size),
      .req_block_offset (req_chan.block_offset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ok           (rsp_chan.ok),
      .rsp_alloc_offset (rsp_chan.alloc_offset),
      .rsp_alloc_order  (rsp_chan.alloc_order),
      .rsp_status       (rsp_chan.status),
      .rsp_live_count   (rsp_chan.live_count)
   );

   assign req_chan.ready = ready;

   // checks
   `BBA_ASSERT_NXT(a_one_in_flight, clock, reset, req_chan.valid && ready, !ready)
   `BBA_ASSERT_NXT(a_load_shows, clock, reset, cmd.op == OP_LOAD_RSP, rsp_chan.valid)
   `BBA_ASSERT_IMP(a_clear_blocks, clock, reset, cmd.op == OP_CLR, !ready)

endmodule
`default_nettype wire
